// File: design/table_syndrome_sec_codec_assert.svh
// Assertion macros for the syndrome-table codec; empty when synthesising.
`ifndef TABLE_SYNDROME_SEC_CODEC_ASSERT_SVH
`define TABLE_SYNDROME_SEC_CODEC_ASSERT_SVH

`ifndef SYNTHESIS

// Checked at every rising edge, suspended while reset is high.
`define TSSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define TSSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define TSSC_ASSERT(lbl, prop, msg)
`define TSSC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: design/tssc_pkg.sv
// Types and constants shared by the syndrome-table codec.
`timescale 1ns / 1ps
`default_nettype none

package tssc_pkg;

  localparam int DATA_W          = 16;
  localparam int CHK_W           = 5;
  localparam int NUM_ENTRIES     = 16;
  localparam int ENTRIES_PER_REG = 8;
  localparam int REG_W           = 40;
  localparam int WORD_W          = 21;
  localparam int POS_W           = 5;
  localparam int CFG_IDX_W       = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SYN_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SYN_HIGH = 1'b1;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_CORRECTED     = 2'd1,
    ST_UNCORRECTABLE = 2'd2
  } status_t;

endpackage

`default_nettype wire

// File: design/tssc_if.sv
// Valid/ready channel interfaces for the codec's requests and results.
`timescale 1ns / 1ps
`default_nettype none

interface tssc_req_if import tssc_pkg::*;;
  logic                valid;
  logic                ready;
  logic                mode;
  logic [DATA_W-1:0]   data_bits;
  logic [CHK_W-1:0]    check_bits;

  modport source (output valid, output mode, output data_bits, output check_bits,
                  input ready);
  modport sink   (input valid, input mode, input data_bits, input check_bits,
                  output ready);
endinterface

interface tssc_res_if import tssc_pkg::*;;
  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   word_out;
  status_t             status;
  logic [POS_W-1:0]    fixed_position;

  modport source (output valid, output word_out, output status, output fixed_position,
                  input ready);
  modport sink   (input valid, input word_out, input status, input fixed_position,
                  output ready);
endinterface

`default_nettype wire

// File: design/table_syndrome_sec_codec.sv
// Top level of the syndrome-table single-error-correcting codec (16 data, 5 check bits).
`timescale 1ns / 1ps
`default_nettype none

`include "table_syndrome_sec_codec_assert.svh"

// Channel   Direction  Handshake     Payload
// request   in         valid/ready   mode, data_bits, check_bits
// result    out        valid/ready   word_out, status, fixed_position
// cfg       in         cfg_we only   cfg_index, cfg_data (syndrome table halves)
//
// One request is taken every cycle unless both registers hold items and the result is
// not taken. Each item passes from the input register through the XOR tree and the
// sixteen parallel table compares into the result register, where it is presented.
// Reset clears both valid flags and the syndrome table to zero.
// A stalled result holds in the result register; the input register still moves into it
// as soon as the result is taken.

module table_syndrome_sec_codec
  import tssc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0]     cfg_data,
  tssc_req_if.sink                  request,
  tssc_res_if.source                result
);

  // Syndrome table, held as the two configuration words.
  logic [REG_W-1:0] syn_low;
  logic [REG_W-1:0] syn_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      syn_low  <= '0;
      syn_high <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYN_LOW:  syn_low  <= cfg_data;
        REG_SYN_HIGH: syn_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register. It advances whenever the result register is free or being emptied.
  logic              s1_valid;
  logic              s1_mode;
  logic [DATA_W-1:0] s1_data;
  logic [CHK_W-1:0]  s1_check;
  logic              s1_adv;
  logic              s1_stall;
  logic              req_take;

  logic              res_valid;
  logic [WORD_W-1:0] res_word;
  status_t           res_status;
  logic [POS_W-1:0]  res_pos;

  assign s1_adv        = !res_valid || result.ready;
  assign s1_stall      = s1_valid && !s1_adv;
  assign request.ready = !s1_valid || s1_adv;
  assign req_take      = request.valid && request.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (request.ready) begin
      s1_valid <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      s1_mode  <= request.mode;
      s1_data  <= request.data_bits;
      s1_check <= request.check_bits;
    end
  end

  // Table entries: entry k (counted from zero here) belongs to data bit DATA_W-1-k.
  logic [CHK_W-1:0] entry [NUM_ENTRIES];

  always_comb begin
    for (int k = 0; k < ENTRIES_PER_REG; k++) begin
      entry[k]                   = syn_low[k*CHK_W +: CHK_W];
      entry[k + ENTRIES_PER_REG] = syn_high[k*CHK_W +: CHK_W];
    end
  end

  // Check value: XOR of the entries of all set data bits.
  logic [CHK_W-1:0] calc_check;

  always_comb begin
    calc_check = '0;
    for (int k = 0; k < NUM_ENTRIES; k++) begin
      if (s1_data[DATA_W-1-k]) begin
        calc_check = calc_check ^ entry[k];
      end
    end
  end

  // Difference against the received check, and its match against every entry at once.
  // The lowest-numbered matching entry wins, so the hit vector is reduced to its lowest set
  // bit, which is then both the flip mask (bit-reversed) and the reported position.
  logic [CHK_W-1:0]       diff;
  logic [NUM_ENTRIES-1:0] hit;
  logic [NUM_ENTRIES-1:0] first_hit;
  logic [DATA_W-1:0]      flip_mask;
  logic [POS_W-1:0]       hit_pos;

  assign diff      = calc_check ^ s1_check;
  assign first_hit = hit & (~hit + NUM_ENTRIES'(1));

  always_comb begin
    for (int k = 0; k < NUM_ENTRIES; k++) begin
      hit[k] = (entry[k] == diff);
    end
  end

  always_comb begin
    flip_mask = '0;
    hit_pos   = '0;
    for (int k = 0; k < NUM_ENTRIES; k++) begin
      flip_mask[DATA_W-1-k] = first_hit[k];
      if (first_hit[k]) begin
        hit_pos = hit_pos | POS_W'(k + 1);
      end
    end
  end

  // Result selection. A zero difference cannot hit a nonzero-difference case, so the
  // mismatch test is made first and a zero entry never causes a false correction.
  logic [WORD_W-1:0] word_next;
  status_t           status_next;
  logic [POS_W-1:0]  pos_next;

  always_comb begin
    word_next   = {{(WORD_W-DATA_W){1'b0}}, s1_data};
    status_next = ST_OK;
    pos_next    = '0;
    if (s1_mode == MODE_ENCODE) begin
      word_next = {s1_data, calc_check};
    end else if (diff != '0) begin
      if (hit != '0) begin
        word_next   = {{(WORD_W-DATA_W){1'b0}}, s1_data ^ flip_mask};
        status_next = ST_CORRECTED;
        pos_next    = hit_pos;
      end else begin
        status_next = ST_UNCORRECTABLE;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      res_word   <= word_next;
      res_status <= status_next;
      res_pos    <= pos_next;
    end
  end

  assign result.valid          = res_valid;
  assign result.word_out       = res_word;
  assign result.status         = res_status;
  assign result.fixed_position = res_pos;

  // Checks on the two-register pipeline.
  `TSSC_ASSERT(a_take_fills_stage, req_take |=> s1_valid, "accepted request not captured")
  `TSSC_ASSERT(a_stage_to_result, (s1_valid && s1_adv) |=> res_valid, "stage item lost")
  `TSSC_ASSERT(a_stage_holds, s1_stall |=> $stable({s1_mode, s1_data, s1_check}), "held item changed")
  `TSSC_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> (!s1_valid && !res_valid), "reset left items")

endmodule

`default_nettype wire
